>>> sv/utf8_stream_validator_defines.svh
// ----------------------------------------------------------------------------
// utf8_stream_validator_defines
// Assertion macros shared by the validator RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define UTF8V_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define UTF8V_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types and constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8v_pkg;

	localparam int BYTE_W  = 8;
	localparam int CP_W    = 21;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_NUL_OK = 1'b0,
		REG_NONE   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic nul_ok;
	} utf8v_cfg_t;

	// verdict produced by the core, one cycle wide
	typedef struct packed {
		logic valid;
		logic string_valid;
	} utf8v_res_t;

endpackage

>>> sv/utf8v_ifs.sv
// ----------------------------------------------------------------------------
// utf8v_ifs
// Valid/ready channels: input bytes and string verdicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface utf8v_byte_if
	import utf8v_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              has_byte;
	logic              end_of_string;

	modport source (output valid, output data_byte, output has_byte,
		output end_of_string, input ready);
	modport sink (input valid, input data_byte, input has_byte,
		input end_of_string, output ready);
endinterface

interface utf8v_verdict_if;
	logic valid;
	logic ready;
	logic string_valid;

	modport source (output valid, output string_valid, input ready);
	modport sink (input valid, input string_valid, output ready);
endinterface

>>> sv/utf8v_cfg.sv
// ----------------------------------------------------------------------------
// utf8v_cfg
// APB register file: the nul_ok control bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8v_cfg
	import utf8v_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output utf8v_cfg_t         cfg
);

	logic     nul_ok_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nul_ok_q <= 1'b0;
		end else if (wr_en && (idx == REG_NUL_OK)) begin
			nul_ok_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_NUL_OK: prdata = {{(PDATA_W-1){1'b0}}, nul_ok_q};
			REG_NONE:   prdata = '0;
			default:    prdata = '0;
		endcase
	end

	assign cfg.nul_ok = nul_ok_q;

endmodule

>>> sv/utf8v_core.sv
// ----------------------------------------------------------------------------
// utf8v_core
// Input register and per-string decode state; one byte checked per cycle unless an end item is held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8v_core
	import utf8v_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  utf8v_cfg_t cfg,
	utf8v_byte_if.sink bytes,
	input  logic       res_stall,
	output utf8v_res_t res
);

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;
	localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              has_s1;
	logic              eos_s1;
	logic              adv;

	// string state
	logic [1:0]      rem_q, rem_n;
	logic [2:0]      len_q, len_n;
	logic [CP_W-1:0] cp_q, cp_n;
	logic            err_q, err_n;

	logic [CP_W-1:0] cp_acc;
	logic [1:0]      rem_dec;

	// an end item waits here while the output register is still full
	assign adv         = valid_s1 && !(eos_s1 && res_stall);
	assign bytes.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
			has_s1  <= bytes.has_byte;
			eos_s1  <= bytes.end_of_string;
		end
	end

	function automatic logic cp_ok(input logic [CP_W-1:0] cp, input logic [2:0] len,
			input logic nul_ok);
		logic ok;
		ok = 1'b0;
		unique case (len)
			LEN_2:   ok = (cp >= 21'h80 && cp <= 21'h7FF) || (cp == '0 && nul_ok);
			LEN_3:   ok = (cp >= 21'h800 && cp <= 21'hFFFF);
			LEN_4:   ok = (cp >= 21'h10000 && cp <= CP_MAX);
			default: ok = 1'b0;
		endcase
		if (cp > CP_MAX || cp[CP_W-1:11] == 10'h01B)
			ok = 1'b0;
		return ok;
	endfunction

	assign cp_acc  = {cp_q[CP_W-7:0], byte_s1[5:0]};
	assign rem_dec = rem_q - 2'd1;

	always_comb begin
		rem_n = rem_q;
		len_n = len_q;
		cp_n  = cp_q;
		err_n = err_q;
		if (has_s1 && !err_q) begin
			if (rem_q == 2'd0) begin
				unique casez (byte_s1)
					8'b0???????: begin
						if (byte_s1 == '0 && !cfg.nul_ok)
							err_n = 1'b1;
					end
					8'b110?????: begin
						len_n = LEN_2;
						cp_n  = {{(CP_W-5){1'b0}}, byte_s1[4:0]};
						rem_n = 2'd1;
					end
					8'b1110????: begin
						len_n = LEN_3;
						cp_n  = {{(CP_W-4){1'b0}}, byte_s1[3:0]};
						rem_n = 2'd2;
					end
					8'b11110???: begin
						len_n = LEN_4;
						cp_n  = {{(CP_W-3){1'b0}}, byte_s1[2:0]};
						rem_n = 2'd3;
					end
					default: err_n = 1'b1;
				endcase
			end else if (byte_s1[7:6] != 2'b10) begin
				err_n = 1'b1;
			end else begin
				cp_n  = cp_acc;
				rem_n = rem_dec;
				if (rem_dec == 2'd0) begin
					if (!cp_ok(cp_acc, len_q, cfg.nul_ok)) begin
						err_n = 1'b1;
					end else begin
						len_n = LEN_NONE;
						cp_n  = '0;
					end
				end
			end
			// an error drops any open sequence
			if (err_n) begin
				rem_n = 2'd0;
				len_n = LEN_NONE;
				cp_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			len_q <= LEN_NONE;
			cp_q  <= '0;
			err_q <= 1'b0;
		end else if (adv) begin
			if (eos_s1) begin
				rem_q <= 2'd0;
				len_q <= LEN_NONE;
				cp_q  <= '0;
				err_q <= 1'b0;
			end else begin
				rem_q <= rem_n;
				len_q <= len_n;
				cp_q  <= cp_n;
				err_q <= err_n;
			end
		end
	end

	assign res.valid        = adv && eos_s1;
	assign res.string_valid = !err_n && (rem_n == 2'd0);

endmodule

>>> sv/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Streaming UTF-8 checker: at most one byte per transaction, one verdict per string.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  bytes     in   valid/ready   data_byte[7:0], has_byte, end_of_string
//  verdict   out  valid/ready   string_valid
//  apb       in   psel/penable  paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
//  One transaction per cycle unless an end item is held; a verdict passes the
//  input and output registers. The string-state decode loop sets that rate.
//  Reset clears nul_ok and all string state; the block is ready at once.
//  A pending verdict holds the next end item in the input register, and
//  that blocks further transactions until the verdict is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_stream_validator_defines.svh"

module utf8_stream_validator
	import utf8v_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	utf8v_byte_if.sink         bytes,
	utf8v_verdict_if.source    verdict,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	utf8v_cfg_t cfg;
	utf8v_res_t res;
	logic       out_valid_q;
	logic       out_data_q;
	logic       res_stall;
	logic       out_hs;

	utf8v_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	utf8v_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.bytes     (bytes),
		.res_stall (res_stall),
		.res       (res)
	);

	assign res_stall = out_valid_q && !verdict.ready;
	assign out_hs    = verdict.valid && verdict.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid)
			out_data_q <= res.string_valid;
	end

	assign verdict.valid        = out_valid_q;
	assign verdict.string_valid = out_data_q;

	`UTF8V_ASSERT_NXT(a_res_lands, clk, arst_n, res.valid, verdict.valid, "verdict lost")
	`UTF8V_ASSERT_IMP(a_no_overwrite, clk, arst_n, res.valid, !res_stall, "verdict overwritten")
	`UTF8V_ASSERT_NXT(a_no_repeat, clk, arst_n, out_hs && !res.valid, !verdict.valid, "repeated")

endmodule
